### rtl/sfcs_pkg.sv
`default_nettype none

package sfcs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SPAN_W      = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 11;
    localparam int INDEX_W     = 10;

    localparam int IN_FIELDS_W = INDEX_W + 2 * VALUE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * VALUE_W;
    localparam int OUT_TUSER_W = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_floor;
        logic [ADDR_W-1:0] addr_ceil;
    } tbl_rd_t;

endpackage

`default_nettype wire

### rtl/sorted_table_floor_ceil_search.sv
`default_nettype none

// Floor and ceiling lookup over a table of signed 32-bit entries kept in ascending order.
// A transaction with tuser 0 writes entry_value at entry_index and returns
// nothing; a transaction with tuser 1 runs a binary search for the floor and the ceiling
// of search_key over the first entry_count entries (saturated to the table depth) and
// returns one result transaction with both values and their found flags. Both searches
// share one table memory with two read ports and run side by side; each probe is one
// registered memory read plus one compare, and a query holds the input until its result
// is loaded into the output register. The next transaction is taken while a result
// still waits on the output register. entry_count is written through cfg_wr_en while no
// query is in flight; the user must keep to this, the block itself does not enforce it.
module sorted_table_floor_ceil_search (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sfcs_pkg::CFG_W-1:0]        cfg_wr_data,   // entry_count
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // entry_index[9:0], entry_value[41:10], search_key[73:42], zero fill above
    input  wire logic [sfcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                              s_axis_tuser,  // command
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // floor_value[31:0], ceil_value[63:32]
    output logic [sfcs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // floor_found[0], ceil_found[1]
    output logic [sfcs_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
    import sfcs_pkg::*;

    logic [CFG_W-1:0]   entry_count_reg;
    logic [SPAN_W-1:0]  used_count;
    logic               s_accept;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic [VALUE_W-1:0] search_key;
    logic               search_idle;
    tbl_wr_t            tbl_wr;
    tbl_rd_t            tbl_rd;
    logic [VALUE_W-1:0] rdata_floor, rdata_ceil;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    assign used_count = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ?
                        SPAN_W'(TABLE_DEPTH) : SPAN_W'(entry_count_reg);

    assign entry_index = s_axis_tdata[INDEX_W-1:0];
    assign entry_value = s_axis_tdata[INDEX_W +: VALUE_W];
    assign search_key  = s_axis_tdata[INDEX_W + VALUE_W +: VALUE_W];

    assign s_axis_tready = search_idle;
    assign s_accept      = s_axis_tvalid && search_idle;

    // indices past the table are dropped
    assign tbl_wr.en   = s_accept && (s_axis_tuser == CMD_WRITE) &&
                         (32'(entry_index) < 32'(TABLE_DEPTH));
    assign tbl_wr.addr = ADDR_W'(entry_index);
    assign tbl_wr.data = entry_value;

    sfcs_table u_table (
        .aclk        (aclk),
        .wr          (tbl_wr),
        .rd          (tbl_rd),
        .rdata_floor (rdata_floor),
        .rdata_ceil  (rdata_ceil)
    );

    sfcs_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .query_start (s_accept && (s_axis_tuser == CMD_QUERY)),
        .query_key   (search_key),
        .used_count  (used_count),
        .idle        (search_idle),
        .rd          (tbl_rd),
        .rdata_floor (rdata_floor),
        .rdata_ceil  (rdata_ceil),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .m_user      (m_axis_tuser)
    );

endmodule

`default_nettype wire

### rtl/sfcs_table.sv
`default_nettype none

module sfcs_table (
    input  wire logic                          aclk,
    input  wire sfcs_pkg::tbl_wr_t             wr,
    input  wire sfcs_pkg::tbl_rd_t             rd,
    output logic [sfcs_pkg::VALUE_W-1:0]       rdata_floor,
    output logic [sfcs_pkg::VALUE_W-1:0]       rdata_ceil
);
    import sfcs_pkg::*;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_floor <= mem[rd.addr_floor];
        rdata_ceil  <= mem[rd.addr_ceil];
    end

endmodule

`default_nettype wire

### rtl/sfcs_search.sv
`default_nettype none

module sfcs_search (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              query_start,
    input  wire logic [sfcs_pkg::VALUE_W-1:0]      query_key,
    input  wire logic [sfcs_pkg::SPAN_W-1:0]       used_count,
    output logic                                   idle,
    output sfcs_pkg::tbl_rd_t                      rd,
    input  wire logic [sfcs_pkg::VALUE_W-1:0]      rdata_floor,
    input  wire logic [sfcs_pkg::VALUE_W-1:0]      rdata_ceil,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [sfcs_pkg::OUT_TDATA_W-1:0]       m_data,
    output logic [sfcs_pkg::OUT_TUSER_W-1:0]       m_user
);
    import sfcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    // half-open windows [lo, hi) for each search
    logic [SPAN_W-1:0]  fl_lo_reg, fl_lo_next, fl_hi_reg, fl_hi_next;
    logic [SPAN_W-1:0]  cl_lo_reg, cl_lo_next, cl_hi_reg, cl_hi_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [VALUE_W-1:0] fl_best_reg, fl_best_next, cl_best_reg, cl_best_next;
    logic               fl_found_reg, fl_found_next, cl_found_reg, cl_found_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_TUSER_W-1:0] m_user_reg, m_user_next;

    logic              fl_active, cl_active;
    logic [SPAN_W:0]   fl_sum, cl_sum;
    logic [ADDR_W-1:0] fl_mid, cl_mid;
    logic              fl_take, cl_take;

    assign fl_active = fl_lo_reg < fl_hi_reg;
    assign cl_active = cl_lo_reg < cl_hi_reg;
    // floor((low + high) / 2) with high = hi - 1; only used while the window is open
    assign fl_sum = {1'b0, fl_lo_reg} + {1'b0, fl_hi_reg} - (SPAN_W + 1)'(1);
    assign cl_sum = {1'b0, cl_lo_reg} + {1'b0, cl_hi_reg} - (SPAN_W + 1)'(1);
    assign fl_mid = fl_sum[ADDR_W:1];
    assign cl_mid = cl_sum[ADDR_W:1];

    assign rd.addr_floor = fl_mid;
    assign rd.addr_ceil  = cl_mid;

    assign fl_take = $signed(rdata_floor) <= $signed(key_reg);
    assign cl_take = $signed(rdata_ceil)  >= $signed(key_reg);

    always_comb begin
        state_next    = state_reg;
        fl_lo_next    = fl_lo_reg;
        fl_hi_next    = fl_hi_reg;
        cl_lo_next    = cl_lo_reg;
        cl_hi_next    = cl_hi_reg;
        key_next      = key_reg;
        fl_best_next  = fl_best_reg;
        cl_best_next  = cl_best_reg;
        fl_found_next = fl_found_reg;
        cl_found_next = cl_found_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (query_start) begin
                    fl_lo_next    = '0;
                    fl_hi_next    = used_count;
                    cl_lo_next    = '0;
                    cl_hi_next    = used_count;
                    key_next      = query_key;
                    fl_best_next  = '0;
                    cl_best_next  = '0;
                    fl_found_next = 1'b0;
                    cl_found_next = 1'b0;
                    state_next    = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // read addresses go out this cycle, data is compared next cycle
                if (fl_active || cl_active) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CHECK: begin
                if (fl_active) begin
                    if (fl_take) begin
                        fl_best_next  = rdata_floor;
                        fl_found_next = 1'b1;
                        fl_lo_next    = SPAN_W'(fl_mid) + SPAN_W'(1);
                    end else begin
                        fl_hi_next    = SPAN_W'(fl_mid);
                    end
                end
                if (cl_active) begin
                    if (cl_take) begin
                        cl_best_next  = rdata_ceil;
                        cl_found_next = 1'b1;
                        cl_hi_next    = SPAN_W'(cl_mid);
                    end else begin
                        cl_lo_next    = SPAN_W'(cl_mid) + SPAN_W'(1);
                    end
                end
                state_next = ST_PROBE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {cl_best_reg, fl_best_reg};
                    m_user_next  = {cl_found_reg, fl_found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fl_lo_reg    <= fl_lo_next;
        fl_hi_reg    <= fl_hi_next;
        cl_lo_reg    <= cl_lo_next;
        cl_hi_reg    <= cl_hi_next;
        key_reg      <= key_next;
        fl_best_reg  <= fl_best_next;
        cl_best_reg  <= cl_best_next;
        fl_found_reg <= fl_found_next;
        cl_found_reg <= cl_found_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign idle    = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule

`default_nettype wire

### rtl/sfcs_checker.sv
`default_nettype none

module sfcs_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [sfcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [sfcs_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import sfcs_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_floor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[VALUE_W-1:0] == '0)
        else $error("floor value nonzero without floor found");

    a_ceil_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[2*VALUE_W-1:VALUE_W] == '0)
        else $error("ceiling value nonzero without ceiling found");

    // a table write from an empty output must not produce a result
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE) && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result after write transaction");

endmodule

bind sorted_table_floor_ceil_search sfcs_checker u_sfcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sfcs_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SMALL_ITEMS   = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] floor_v;
        logic               floor_f;
        logic [VALUE_W-1:0] ceil_v;
        logic               ceil_f;
    } bound_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] data;
        logic               typed;
        bound_t             want;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // testbench copy of the table, the count register and what was written
    logic [VALUE_W-1:0] entry_mirror [TABLE_DEPTH];
    bit                 written_mask [TABLE_DEPTH];
    logic [CFG_W-1:0]   count_mirror;

    bound_t   pending_bounds [$];
    dir_row_t dir_rows [$];
    int       bad_results;
    int       items_sent;
    int       burst_left;
    int       idle_cycles;
    bit       hold_request;

    sorted_table_floor_ceil_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    // binary search for floor and ceiling over the entries in use
    function automatic bound_t floor_ceil_lookup(input logic [VALUE_W-1:0] key);
        bound_t                    r;
        int                        used;
        int                        lo;
        int                        hi;
        int                        mid;
        logic signed [VALUE_W-1:0] e;
        logic signed [VALUE_W-1:0] k;
        r = '0;
        k = key;
        used = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
        lo = 0;
        hi = used - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            e = entry_mirror[mid];
            if (e <= k) begin
                r.floor_v = e;
                r.floor_f = 1'b1;
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        lo = 0;
        hi = used - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            e = entry_mirror[mid];
            if (e >= k) begin
                r.ceil_v = e;
                r.ceil_f = 1'b1;
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    function automatic dir_row_t mk_row(input row_kind_t kind, input logic [INDEX_W-1:0] idx,
                                        input logic [VALUE_W-1:0] data, input logic typed,
                                        input logic [VALUE_W-1:0] fv, input logic ff,
                                        input logic [VALUE_W-1:0] cv, input logic cf);
        dir_row_t r;
        r.kind = kind;
        r.idx = idx;
        r.data = data;
        r.typed = typed;
        r.want.floor_v = fv;
        r.want.floor_f = ff;
        r.want.ceil_v = cv;
        r.want.ceil_f = cf;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_key(input int used);
        logic [VALUE_W-1:0] e;
        if (used == 0) return $urandom();
        e = entry_mirror[$urandom_range(0, used - 1)];
        case ($urandom_range(0, 7))
            0, 1: return e;
            2: return e + 1;
            3: return e - 1;
            4: return 32'h8000_0000;
            5: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val, input logic [VALUE_W-1:0] key,
                             input logic typed, input bound_t typed_bound);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[INDEX_W-1:0] = idx;
        word[INDEX_W +: VALUE_W] = val;
        word[INDEX_W + VALUE_W +: VALUE_W] = key;
        @(negedge aclk);
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
        if (cmd == CMD_WRITE) begin
            entry_mirror[idx] = val;
            written_mask[idx] = 1'b1;
        end else begin
            pending_bounds.push_back(typed ? typed_bound : floor_ceil_lookup(key));
        end
    endtask

    // the count register only moves while no query is in flight
    task automatic set_entry_count(input logic [CFG_W-1:0] n);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        count_mirror = n;
    endtask

    task automatic fill_sorted(input int used);
        longint      level;
        int unsigned max_step;
        int          k;
        case ($urandom_range(0, 2))
            0: begin
                // narrow range with many duplicates
                level = longint'($urandom_range(0, 200)) - 100;
                max_step = 3;
            end
            1: begin
                level = longint'($signed($urandom()));
                max_step = 1000;
            end
            default: begin
                // spread over the whole signed range
                level = -64'sd2147483648 + $urandom_range(0, 3);
                max_step = (used > 0) ? 32'hffff_ffff / used : 0;
            end
        endcase
        for (k = 0; k < used; k++) begin
            if (k > 0) level = level + $urandom_range(0, max_step);
            if (level > 64'sd2147483647) level = 64'sd2147483647;
            send_item(CMD_WRITE, k[INDEX_W-1:0], level[VALUE_W-1:0], $urandom(), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int n, input int queries, input bit press);
        int used;
        int k;
        bit table_ready;
        used = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
        table_ready = 1'b1;
        for (k = 0; k < used; k++) if (!written_mask[k]) table_ready = 1'b0;
        if (!table_ready || (used <= 64 && $urandom_range(0, 9) < 6)) fill_sorted(used);
        set_entry_count(n[CFG_W-1:0]);
        if (press) hold_request = 1'b1;
        for (k = 0; k < queries; k++) begin
            // an odd write in between, which may break the ordering
            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_WRITE, $urandom_range(0, TABLE_DEPTH - 1), $urandom(),
                          $urandom(), 1'b0, '0);
            end else begin
                send_item(CMD_QUERY, $urandom_range(0, TABLE_DEPTH - 1), $urandom(),
                          pick_key(used), 1'b0, '0);
            end
        end
    endtask

    // result checking
    always @(posedge aclk) begin
        bound_t seen;
        bound_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.floor_v = m_axis_tdata[VALUE_W-1:0];
            seen.ceil_v  = m_axis_tdata[2*VALUE_W-1:VALUE_W];
            seen.floor_f = m_axis_tuser[0];
            seen.ceil_f  = m_axis_tuser[1];
            if (pending_bounds.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: floor %0d/%0b ceil %0d/%0b",
                             $signed(seen.floor_v), seen.floor_f,
                             $signed(seen.ceil_v), seen.ceil_f);
            end else begin
                want = pending_bounds.pop_front();
                if (seen.floor_v !== want.floor_v || seen.floor_f !== want.floor_f ||
                    seen.ceil_v !== want.ceil_v || seen.ceil_f !== want.ceil_f) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: floor %0d/%0b ceil %0d/%0b, want %0d/%0b %0d/%0b",
                                 $signed(seen.floor_v), seen.floor_f,
                                 $signed(seen.ceil_v), seen.ceil_f,
                                 $signed(want.floor_v), want.floor_f,
                                 $signed(want.ceil_v), want.ceil_f);
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        int mode;
        int span;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge aclk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            while (span > 0 && !hold_request) begin
                @(negedge aclk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
                span--;
            end
        end
    end

    initial begin
        int i;
        int n;
        int sel;
        int small_goal;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        count_mirror  = '0;
        bad_results   = 0;
        items_sent    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;

        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h0000_0000, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h8000_0000, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 1, 32'hffff_fffb, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 2, 32'h0000_0000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 3, 32'h0000_0007, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 4, 32'h7fff_ffff, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 1023, 32'h5a5a_5a5a, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_CFG, 0, 5, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h8000_0000, 1,
                                  32'h8000_0000, 1, 32'h8000_0000, 1));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h7fff_ffff, 1,
                                  32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'hffff_fffa, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h0000_0003, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h0000_0007, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_WRITE, 0, 32'hffff_ff9c, 0, 0, 0, 0, 0));
        // key below every entry: no floor
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'hffff_fc18, 1, 0, 0, 32'hffff_ff9c, 1));
        dir_rows.push_back(mk_row(ROW_CFG, 0, 4, 0, 0, 0, 0, 0));
        // key above every entry: no ceiling
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h7fff_ffff, 1, 32'h0000_0007, 1, 0, 0));
        dir_rows.push_back(mk_row(ROW_CFG, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'hffff_ff9c, 1,
                                  32'hffff_ff9c, 1, 32'hffff_ff9c, 1));
        // out of order last entry
        dir_rows.push_back(mk_row(ROW_WRITE, 5, 32'hffff_ffce, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_CFG, 0, 6, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'hffff_ffd8, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_QUERY, 0, 32'h0000_0000, 0, 0, 0, 0, 0));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: set_entry_count(dir_rows[i].data[CFG_W-1:0]);
                ROW_WRITE: send_item(CMD_WRITE, dir_rows[i].idx, dir_rows[i].data,
                                     $urandom(), 1'b0, '0);
                default: send_item(CMD_QUERY, $urandom_range(0, TABLE_DEPTH - 1), $urandom(),
                                   dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
            endcase
        end

        // mostly short tables
        small_goal = items_sent + SMALL_ITEMS;
        i = 0;
        while (items_sent < small_goal) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) n = $urandom_range(0, 8);
            else if (sel < 9) n = $urandom_range(9, 40);
            else n = $urandom_range(41, 200);
            run_phase(n, $urandom_range(8, 24), i == 3);
            i++;
        end

        // full depth, then counts past the depth, then empty again, then a short table
        run_phase(TABLE_DEPTH, 30, 1'b1);
        run_phase(2047, 16, 1'b0);
        run_phase(TABLE_DEPTH + 1, 8, 1'b0);
        run_phase(0, 4, 1'b0);
        run_phase($urandom_range(1, 12), 20, 1'b0);

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (bad_results == 0 && pending_bounds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
